[design/dq_pkg.sv]
// Shared types and codes for the double-ended queue.
`timescale 1ns / 1ps
package dq_pkg;

  typedef enum logic [2:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_BACK   = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_READ_INDEX = 3'd4
  } dq_op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } dq_status_e;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] value;
    logic [5:0]  index;
  } dq_in_t;

  typedef struct packed {
    logic [31:0] data;
    logic [1:0]  status;
    logic [6:0]  count;
  } dq_out_t;

  // Access request from the pointer logic for the item being accepted.
  typedef struct packed {
    logic       we;
    logic       re;
    dq_status_e status;
  } dq_ctrl_t;

  typedef enum logic [1:0] {
    FSM_IDLE = 2'b01,
    FSM_READ = 2'b10
  } dq_fsm_e;

endpackage

[design/dq_ram.sv]
// Ring store: single-port synchronous memory with registered read data.
`timescale 1ns / 1ps
module dq_ram #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [DATA_WIDTH-1:0]    wdata_i,
  output logic [DATA_WIDTH-1:0]    rdata_o
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/dq_ctrl.sv]
// Head pointer, element count, operation decode and store address generation.
`timescale 1ns / 1ps
module dq_ctrl #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       fire_i,
  input  dq_pkg::dq_in_t             item_i,
  output dq_pkg::dq_ctrl_t           ctrl_o,
  output logic [$clog2(DEPTH)-1:0]   addr_o,
  output logic [DATA_WIDTH-1:0]      wdata_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);
  import dq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int OW = (CW > 6) ? CW : 6;
  localparam int SW = CW + 1;

  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] offset;
  logic [SW-1:0] sum;
  logic [SW-1:0] slot;
  logic [AW-1:0] head_dec;
  logic [AW-1:0] head_inc;
  logic [OW-1:0] idx_ext;
  logic [OW-1:0] cnt_ext;
  logic          full;
  logic          empty;
  logic          use_head;
  logic [DATA_WIDTH+31:0] value_ext;
  dq_ctrl_t      ctrl;

  assign full     = (count_q == CW'(DEPTH));
  assign empty    = (count_q == '0);
  assign idx_ext  = OW'(item_i.index);
  assign cnt_ext  = OW'(count_q);
  assign head_dec = (head_q == '0) ? AW'(DEPTH - 1) : head_q - 1'b1;
  assign head_inc = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + 1'b1;

  // For every accepted access the sum stays below twice the depth, so one subtract wraps it.
  assign sum  = SW'(head_q) + SW'(offset);
  assign slot = (sum >= SW'(DEPTH)) ? sum - SW'(DEPTH) : sum;

  assign value_ext = {{DATA_WIDTH{1'b0}}, item_i.value};
  assign wdata_o   = value_ext[DATA_WIDTH-1:0];

  always_comb begin
    ctrl        = '{we: 1'b0, re: 1'b0, status: ST_OK};
    offset      = count_q;
    use_head    = 1'b0;
    head_d      = head_q;
    count_d     = count_q;
    case (dq_op_e'(item_i.op))
      OP_PUSH_BACK: begin
        if (full) begin
          ctrl.status = ST_FULL;
        end else begin
          ctrl.we = 1'b1;
          count_d = count_q + 1'b1;
        end
      end
      OP_PUSH_FRONT: begin
        use_head = 1'b1;
        if (full) begin
          ctrl.status = ST_FULL;
        end else begin
          ctrl.we = 1'b1;
          head_d  = head_dec;
          count_d = count_q + 1'b1;
        end
      end
      OP_POP_BACK: begin
        offset = count_q - 1'b1;
        if (empty) begin
          ctrl.status = ST_EMPTY;
        end else begin
          ctrl.re = 1'b1;
          count_d = count_q - 1'b1;
        end
      end
      OP_POP_FRONT: begin
        use_head = 1'b1;
        if (empty) begin
          ctrl.status = ST_EMPTY;
        end else begin
          ctrl.re = 1'b1;
          head_d  = head_inc;
          count_d = count_q - 1'b1;
        end
      end
      OP_READ_INDEX: begin
        offset = idx_ext[CW-1:0];
        if (idx_ext >= cnt_ext) begin
          ctrl.status = ST_RANGE;
        end else begin
          ctrl.re = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Push front writes the slot ahead of the head; pop front reads the head.
  always_comb begin
    if (use_head) begin
      addr_o = (dq_op_e'(item_i.op) == OP_PUSH_FRONT) ? head_dec : head_q;
    end else begin
      addr_o = slot[AW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else if (fire_i) begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  assign ctrl_o  = '{we: ctrl.we & fire_i, re: ctrl.re & fire_i, status: ctrl.status};
  assign count_o = count_d;

endmodule

[design/double_ended_queue.sv]
// Top level of the double-ended queue: handshakes, sequencing and result register.
//
//   channel | dir | handshake              | payload
//   --------+-----+------------------------+------------------------------
//   in      | in  | in_valid_i, in_ready_o | in_item_i  (op, value, index)
//   out     | out | out_valid_o, out_ready_i | out_item_o (data, status, count)
//
// Pushes, refused operations and unused op codes go straight to the result
// register; pops and indexed reads first wait in the read state for store data.
// One item is in flight at a time; a new item is taken in the cycle its
// predecessor's result leaves. A stalled result holds the result register
// and blocks new items. Reset clears the head pointer, the count and all
// handshake state; the store needs no clearing.
`timescale 1ns / 1ps
module double_ended_queue #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  dq_pkg::dq_in_t  in_item_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output dq_pkg::dq_out_t out_item_o
);
  import dq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  dq_fsm_e               state_q, state_d;
  logic                  out_valid_q, out_valid_d;
  dq_out_t               out_q, out_d;
  logic                  fire;
  dq_ctrl_t              ctrl;
  logic [AW-1:0]         addr;
  logic [DATA_WIDTH-1:0] wdata;
  logic [DATA_WIDTH-1:0] rdata;
  logic [CW-1:0]         count;
  logic [CW+6:0]         count_ext;
  logic [DATA_WIDTH+31:0] rdata_ext;

  assign in_ready_o = (state_q == FSM_IDLE) && (!out_valid_q || out_ready_i);
  assign fire       = in_valid_i && in_ready_o;

  dq_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (fire),
    .item_i  (in_item_i),
    .ctrl_o  (ctrl),
    .addr_o  (addr),
    .wdata_o (wdata),
    .count_o (count)
  );

  dq_ram #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ctrl.we),
    .re_i    (ctrl.re),
    .addr_i  (addr),
    .wdata_i (wdata),
    .rdata_o (rdata)
  );

  assign count_ext = {7'b0, count};
  assign rdata_ext = {32'b0, rdata};

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    case (state_q)
      FSM_IDLE: begin
        if (fire) begin
          out_d.data   = '0;
          out_d.status = ctrl.status;
          out_d.count  = count_ext[6:0];
          if (ctrl.re) begin
            state_d = FSM_READ;
          end else begin
            out_valid_d = 1'b1;
          end
        end
      end
      FSM_READ: begin
        // Status and count were captured at accept; only the data arrives now.
        out_d.data  = rdata_ext[31:0];
        out_valid_d = 1'b1;
        state_d     = FSM_IDLE;
      end
      default: begin
        state_d = FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_no_accept_in_read: assert property (
    @(posedge clk_i) disable iff (!rst_ni) (state_q == FSM_READ) |-> !in_ready_o
  ) else $error("item accepted while a store read is pending");

  a_read_enters_wait: assert property (
    @(posedge clk_i) disable iff (!rst_ni) (fire && ctrl.re) |=> (state_q == FSM_READ)
  ) else $error("store read issued without waiting for its data");

  a_read_gives_result: assert property (
    @(posedge clk_i) disable iff (!rst_ni) (state_q == FSM_READ) |=> out_valid_o
  ) else $error("read data not presented as a result");

  a_ok_read_only_when_status_ok: assert property (
    @(posedge clk_i) disable iff (!rst_ni) (fire && ctrl.re) |-> (ctrl.status == ST_OK)
  ) else $error("store read issued for a refused operation");

endmodule
